// File: rtl/core/qrk_pkg.sv
// Shared types and constants for the keyed-remove queue.
`default_nettype none
package qrk_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 5;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic              load_req;
    logic              push;
    logic              scan_start;
    logic              scan_step;
    logic              remove_done;
    logic              list_emit;
    logic              emit_resp;
    logic [STAT_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            scan_last;
    logic            hit;
    logic            out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/qrk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module qrk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/qrk_datapath.sv
// Queue storage, count, scan index and output register.
`default_nettype none
module qrk_datapath #(
  parameter int DEPTH = qrk_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire qrk_pkg::cmd_t                    cmd,
  output qrk_pkg::stat_t                        st,
  input  wire logic [qrk_pkg::OP_W-1:0]         opcode,
  input  wire logic signed [qrk_pkg::ID_W-1:0]  entry_id,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic signed [qrk_pkg::ID_W-1:0]       entry_value,
  output logic [qrk_pkg::STAT_W-1:0]            status,
  output logic                                  last_of_run,
  output logic [qrk_pkg::OCC_W-1:0]             occupancy
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [qrk_pkg::OP_W-1:0]        req_op;
  logic signed [qrk_pkg::ID_W-1:0] req_id;
  logic [CNT_W-1:0]                count;
  logic [IDX_W-1:0]                rd_idx;
  logic                            found;
  logic [qrk_pkg::ID_W-1:0]        rd_data;
  logic                            match;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  logic [qrk_pkg::ID_W-1:0]        wr_data;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  logic [CNT_W+qrk_pkg::OCC_W-1:0] cnt_ext;

  assign match   = (rd_data == req_id);
  assign cnt_ext = {{qrk_pkg::OCC_W{1'b0}}, count};

  always_comb begin
    st.op        = req_op;
    st.full      = (count == CNT_W'(DEPTH));
    st.empty     = (count == '0);
    st.scan_last = (CNT_W'(rd_idx) + CNT_W'(1) == count);
    st.hit       = found | match;
    st.out_free  = !rsp_valid || rsp_ready;
  end

  // push writes at the tail; during a scan entries past the hit move one slot up
  always_comb begin
    wr_en   = cmd.push | (cmd.scan_step & found);
    wr_addr = cmd.push ? count[IDX_W-1:0] : rd_idx - IDX_W'(1);
    wr_data = cmd.push ? req_id : rd_data;
    rd_en   = cmd.scan_start | cmd.scan_step | cmd.list_emit;
    rd_addr = cmd.scan_start ? '0 : rd_idx + IDX_W'(1);
  end

  qrk_ram #(
    .WIDTH(qrk_pkg::ID_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op <= opcode;
      req_id <= entry_id;
    end
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
    if (cmd.scan_start) begin
      found <= 1'b0;
    end else if (cmd.scan_step && match) begin
      found <= 1'b1;
    end
    if (cmd.list_emit) begin
      entry_value <= rd_data;
      status      <= qrk_pkg::ST_OK;
      last_of_run <= st.scan_last;
      occupancy   <= cnt_ext[qrk_pkg::OCC_W-1:0];
    end else if (cmd.emit_resp) begin
      entry_value <= (req_op == qrk_pkg::OP_LIST) ? '0 : req_id;
      status      <= cmd.code;
      last_of_run <= 1'b1;
      occupancy   <= cnt_ext[qrk_pkg::OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + CNT_W'(1);
      end else if (cmd.remove_done && st.hit) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.list_emit || cmd.emit_resp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/qrk_ctrl.sv
// Sequencer for push, remove-scan, list and single responses.
`default_nettype none
module qrk_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire qrk_pkg::stat_t st,
  output qrk_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LIST   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [qrk_pkg::STAT_W-1:0]  resp_st;
  logic [qrk_pkg::STAT_W-1:0]  resp_st_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    resp_st_next = resp_st;
    cmd          = '0;
    cmd.code     = resp_st;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next   = S_RESP;
        resp_st_next = qrk_pkg::ST_OK;
        case (st.op)
          qrk_pkg::OP_PUSH: begin
            if (st.full) begin
              resp_st_next = qrk_pkg::ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          qrk_pkg::OP_REMOVE: begin
            if (st.empty) begin
              resp_st_next = qrk_pkg::ST_NOT_FOUND;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          qrk_pkg::OP_LIST: begin
            if (st.empty) begin
              resp_st_next = qrk_pkg::ST_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_LIST;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          cmd.remove_done = 1'b1;
          resp_st_next    = st.hit ? qrk_pkg::ST_OK : qrk_pkg::ST_NOT_FOUND;
          state_next      = S_RESP;
        end
      end
      S_LIST: begin
        if (st.out_free) begin
          cmd.list_emit = 1'b1;
          if (st.scan_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.emit_resp = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    resp_st <= resp_st_next;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/queue_with_remove_by_key.sv
// Top level of the ordered id queue with push, remove-by-key and list.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+----------------------------------------------
//   request | req_valid | req_ready | opcode, entry_id
//   result  | rsp_valid | rsp_ready | entry_value, status, last_of_run, occupancy
//
// One request at a time. Push and unused opcodes go from decode straight to the response;
// remove reads the RAM once per held entry while shifting later entries up, and list
// sends one entry per cycle through the RAM read port while the result register is free.
// Result register stalls hold the list walk; the next request is taken while
// the final result still waits. Synchronous reset empties the queue.
`default_nettype none
module queue_with_remove_by_key #(
  parameter int DEPTH = qrk_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire logic [qrk_pkg::OP_W-1:0]         opcode,
  input  wire logic signed [qrk_pkg::ID_W-1:0]  entry_id,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic signed [qrk_pkg::ID_W-1:0]       entry_value,
  output logic [qrk_pkg::STAT_W-1:0]            status,
  output logic                                  last_of_run,
  output logic [qrk_pkg::OCC_W-1:0]             occupancy
);

  qrk_pkg::cmd_t  dp_cmd;
  qrk_pkg::stat_t dp_st;

  qrk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .st       (dp_st),
    .cmd      (dp_cmd)
  );

  qrk_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .st         (dp_st),
    .opcode     (opcode),
    .entry_id   (entry_id),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .entry_value(entry_value),
    .status     (status),
    .last_of_run(last_of_run),
    .occupancy  (occupancy)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.push |-> !dp_st.full)
    else $error("push issued on a full queue");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.list_emit || dp_cmd.emit_resp) |-> dp_st.out_free)
    else $error("result register overwritten before transfer");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one in progress");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(dp_cmd.list_emit && dp_cmd.emit_resp))
    else $error("two result sources in one cycle");

endmodule
`default_nettype wire
